// ----- rtl/core/upn_pkg.sv -----
`default_nettype none

package upn_pkg;

  // Output limit for one path; any byte that would bring the count to it rejects.
  localparam int unsigned CAPACITY = 4096;
  localparam int unsigned CNT_W    = $clog2(CAPACITY);

  localparam logic [CNT_W:0]   CAP_EXT  = (CNT_W + 1)'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_LAST = CNT_W'(CAPACITY - 1);

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Length and start position of the two index suffixes.
  localparam logic [3:0] SUFFIX_LEN_FULL = 4'd11;
  localparam logic [3:0] SUFFIX_LEN_BARE = 4'd10;
  localparam logic [3:0] SUFFIX_POS_FULL = 4'd0;
  localparam logic [3:0] SUFFIX_POS_BARE = 4'd1;

  // Start positions in the content string "/..b/.b/b".
  localparam logic [3:0] CONTENT_LAST         = 4'd3;  // "b", ".b", "..b" end here
  localparam logic [3:0] CONTENT_POS_SEP      = 4'd7;  // "/b"
  localparam logic [3:0] CONTENT_POS_SEP_DOT  = 4'd4;  // "/.b"
  localparam logic [3:0] CONTENT_POS_SEP_DOTS = 4'd0;  // "/..b"

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    SEG_NONE   = 2'd0,
    SEG_DOT    = 2'd1,
    SEG_DOTDOT = 2'd2,
    SEG_KEPT   = 2'd3
  } seg_e;

  // Where the bytes of a burst come from: the "/..b/.b/b" content string or "/index.html".
  typedef enum logic {
    SRC_CONTENT = 1'b0,
    SRC_SUFFIX  = 1'b1
  } src_e;

  // One burst of results caused by one input transfer.
  typedef struct packed {
    src_e       src;
    logic [7:0] data;
    logic [3:0] pos;
    logic [3:0] nbytes;
    logic       end_item;
    logic       end_rej;
  } burst_t;

  function automatic logic [7:0] burst_char(src_e src, logic [3:0] pos, logic [7:0] data);
    logic [7:0] ch;
    ch = 8'h00;
    if (src == SRC_CONTENT) begin
      case (pos)
        4'd0:    ch = CH_SLASH;
        4'd1:    ch = CH_DOT;
        4'd2:    ch = CH_DOT;
        4'd3:    ch = data;
        4'd4:    ch = CH_SLASH;
        4'd5:    ch = CH_DOT;
        4'd6:    ch = data;
        4'd7:    ch = CH_SLASH;
        4'd8:    ch = data;
        default: ch = 8'h00;
      endcase
    end else begin
      case (pos)
        4'd0:    ch = CH_SLASH;
        4'd1:    ch = 8'h69; // i
        4'd2:    ch = 8'h6E; // n
        4'd3:    ch = 8'h64; // d
        4'd4:    ch = 8'h65; // e
        4'd5:    ch = 8'h78; // x
        4'd6:    ch = CH_DOT;
        4'd7:    ch = 8'h68; // h
        4'd8:    ch = 8'h74; // t
        4'd9:    ch = 8'h6D; // m
        4'd10:   ch = 8'h6C; // l
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/upn_emit.sv -----
`default_nettype none

// Two-slot burst queue: a waiting slot and an active slot that plays out
// one result per transfer.
module upn_emit (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  load_valid_i,
  input  wire upn_pkg::burst_t load_burst_i,
  output logic                 load_ready_o,
  output logic                 m_axis_tvalid_o,
  input  wire                  m_axis_tready_i,
  output logic [7:0]           m_axis_tdata_o,   // out_byte
  output logic [1:0]           m_axis_tuser_o,   // kind
  output logic                 m_axis_tlast_o    // run_end
);

  upn_pkg::burst_t wait_q, wait_d, act_q, act_d;
  logic            wait_valid_q, wait_valid_d;
  logic            act_busy, act_last, take, act_free, move;

  always_comb begin
    act_busy = (act_q.nbytes != 4'd0) || act_q.end_item;
    act_last = ((act_q.nbytes == 4'd1) && !act_q.end_item) ||
               ((act_q.nbytes == 4'd0) && act_q.end_item);
    take     = act_busy && m_axis_tready_i;
    act_free = !act_busy || (take && act_last);
    move     = wait_valid_q && act_free;
  end

  assign load_ready_o    = !wait_valid_q || move;
  assign m_axis_tvalid_o = act_busy;
  assign m_axis_tlast_o  = (act_q.nbytes == 4'd0);

  always_comb begin
    if (act_q.nbytes != 4'd0) begin
      m_axis_tdata_o = upn_pkg::burst_char(act_q.src, act_q.pos, act_q.data);
      m_axis_tuser_o = upn_pkg::KIND_BYTE;
    end else begin
      m_axis_tdata_o = 8'h00;
      m_axis_tuser_o = act_q.end_rej ? upn_pkg::KIND_REJECT : upn_pkg::KIND_ACCEPT;
    end
  end

  always_comb begin
    act_d = act_q;
    if (move) begin
      act_d = wait_q;
    end else if (take) begin
      if (act_q.nbytes != 4'd0) begin
        act_d.nbytes = act_q.nbytes - 4'd1;
        act_d.pos    = act_q.pos + 4'd1;
      end else begin
        act_d.end_item = 1'b0;
      end
    end
    wait_d       = wait_q;
    wait_valid_d = wait_valid_q;
    if (load_valid_i) begin
      wait_d       = load_burst_i;
      wait_valid_d = 1'b1;
    end else if (move) begin
      wait_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q        <= '0;
      wait_valid_q <= 1'b0;
    end else begin
      act_q        <= act_d;
      wait_valid_q <= wait_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wait_q <= wait_d;
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_valid_i |-> load_ready_o)
    else $error("burst loaded while the waiting slot is held");

  a_burst_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q.nbytes <= upn_pkg::SUFFIX_LEN_FULL)
    else $error("burst longer than the index suffix");

  a_end_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && act_last && !wait_valid_q) |=> !m_axis_tvalid_o)
    else $error("results appear with no burst queued");

  a_last_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tuser_o != upn_pkg::KIND_BYTE))
    else $error("terminal item carries a path byte");

endmodule

`default_nettype wire

// ----- rtl/core/url_path_normalizer_top.sv -----
`default_nettype none
// Flow: the burst of an accepted input transfer goes to the waiting slot, then to the active slot.
// Throughput: one input byte per cycle while each byte yields at most one result and the output
//   is not held; a byte that yields more results (up to 12, set by the index suffix) holds input.
// Reset: rst_ni is asynchronous, active low; it clears the path state and the burst queue.

module url_path_normalizer_top (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  wire  [7:0] s_axis_tdata_i,   // path_byte
  input  wire        s_axis_tlast_i,   // final_byte
  output logic       m_axis_tvalid_o,
  input  wire        m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // out_byte
  output logic [1:0] m_axis_tuser_o,   // kind
  output logic       m_axis_tlast_o    // run_end
);

  localparam int unsigned CW = upn_pkg::CNT_W;

  // Per-path state. Held dots are always '.', so only their count is kept.
  logic           first_seen_q, first_seen_d;
  logic           rejected_q, rejected_d;
  logic [CW-1:0]  out_count_q, out_count_d;
  upn_pkg::seg_e  seg_q, seg_d;
  logic           prev_slash_q, prev_slash_d;

  logic            accept;
  logic            load_valid;
  logic            load_ready;
  upn_pkg::burst_t burst;

  // Working values of the single pass over one byte.
  logic            rej;
  logic            content_emit;
  logic            content_sep;
  logic [3:0]      content_dots;
  logic [3:0]      req_len;
  logic [3:0]      req_pos;
  upn_pkg::src_e   req_src;
  logic [CW:0]     count_sum;
  logic [CW-1:0]   avail;
  logic            over;
  logic [3:0]      n_emit;

  assign s_axis_tready_o = load_ready;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    first_seen_d = first_seen_q;
    rejected_d   = rejected_q;
    seg_d        = seg_q;
    prev_slash_d = prev_slash_q;
    rej          = rejected_q;
    content_emit = 1'b0;
    content_dots = 4'd0;
    content_sep  = 1'b0;
    req_len      = 4'd0;
    req_pos      = 4'd0;
    req_src      = upn_pkg::SRC_CONTENT;

    if (!first_seen_q) begin
      // Leading byte: must be the root slash.
      first_seen_d = 1'b1;
      prev_slash_d = 1'b1;
      if (s_axis_tdata_i != upn_pkg::CH_SLASH) begin
        rej = 1'b1;
      end
    end else if (!rejected_q) begin
      if (s_axis_tdata_i == upn_pkg::CH_SLASH) begin
        // Close the open segment; a held ".." is a parent reference and rejects.
        if (seg_q == upn_pkg::SEG_DOTDOT) begin
          rej = 1'b1;
        end
        seg_d        = upn_pkg::SEG_NONE;
        prev_slash_d = 1'b1;
      end else begin
        prev_slash_d = 1'b0;
        if ((s_axis_tdata_i == upn_pkg::CH_BSLASH) || (s_axis_tdata_i == upn_pkg::CH_NUL)) begin
          rej = 1'b1;
        end else begin
          case (seg_q)
            upn_pkg::SEG_NONE: begin
              if (s_axis_tdata_i == upn_pkg::CH_DOT) begin
                seg_d = upn_pkg::SEG_DOT;
              end else begin
                content_emit = 1'b1;
                content_sep  = (out_count_q != '0);
                seg_d        = upn_pkg::SEG_KEPT;
              end
            end
            upn_pkg::SEG_DOT: begin
              if (s_axis_tdata_i == upn_pkg::CH_DOT) begin
                seg_d = upn_pkg::SEG_DOTDOT;
              end else begin
                content_emit = 1'b1;
                content_dots = 4'd1;
                content_sep  = (out_count_q != '0);
                seg_d        = upn_pkg::SEG_KEPT;
              end
            end
            upn_pkg::SEG_DOTDOT: begin
              // Release the held dots: the segment is longer than "..".
              content_emit = 1'b1;
              content_dots = 4'd2;
              content_sep  = (out_count_q != '0);
              seg_d        = upn_pkg::SEG_KEPT;
            end
            default: begin
              content_emit = 1'b1;
            end
          endcase
        end
      end
    end

    if (content_emit) begin
      req_src = upn_pkg::SRC_CONTENT;
      req_len = 4'd1 + content_dots + {3'd0, content_sep};
      // Pick the stretch of "/..b/.b/b" that carries the separator and held dots.
      if (!content_sep) begin
        req_pos = upn_pkg::CONTENT_LAST - content_dots;
      end else begin
        case (content_dots)
          4'd0:    req_pos = upn_pkg::CONTENT_POS_SEP;
          4'd1:    req_pos = upn_pkg::CONTENT_POS_SEP_DOT;
          default: req_pos = upn_pkg::CONTENT_POS_SEP_DOTS;
        endcase
      end
    end

    // Last byte: close the segment and pick the index suffix. A byte emitted on this
    // transfer leaves prev_slash clear and the count non-zero, so no suffix follows it.
    if (s_axis_tlast_i && !rej && !content_emit) begin
      if (seg_d == upn_pkg::SEG_DOTDOT) begin
        rej = 1'b1;
      end else if (out_count_q == '0) begin
        req_src = upn_pkg::SRC_SUFFIX;
        req_len = upn_pkg::SUFFIX_LEN_BARE;
        req_pos = upn_pkg::SUFFIX_POS_BARE;
      end else if (prev_slash_d) begin
        req_src = upn_pkg::SRC_SUFFIX;
        req_len = upn_pkg::SUFFIX_LEN_FULL;
        req_pos = upn_pkg::SUFFIX_POS_FULL;
      end
    end

    // Capacity: emit what fits below the limit, then reject.
    count_sum = {1'b0, out_count_q} + {{(CW - 3){1'b0}}, req_len};
    avail     = upn_pkg::CAP_LAST - out_count_q;
    over      = (count_sum >= upn_pkg::CAP_EXT);
    n_emit    = over ? avail[3:0] : req_len;
    if (over) begin
      rej = 1'b1;
    end
    out_count_d = out_count_q + {{(CW - 4){1'b0}}, n_emit};
    rejected_d  = rej;

    burst.src      = req_src;
    burst.data     = s_axis_tdata_i;
    burst.pos      = req_pos;
    burst.nbytes   = n_emit;
    burst.end_item = s_axis_tlast_i;
    burst.end_rej  = rej;

    // End of path: start the next one from scratch.
    if (s_axis_tlast_i) begin
      first_seen_d = 1'b0;
      rejected_d   = 1'b0;
      out_count_d  = '0;
      seg_d        = upn_pkg::SEG_NONE;
      prev_slash_d = 1'b0;
    end
  end

  // Drop bursts with nothing in them.
  assign load_valid = accept && ((n_emit != 4'd0) || s_axis_tlast_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_seen_q <= 1'b0;
      rejected_q   <= 1'b0;
      out_count_q  <= '0;
      seg_q        <= upn_pkg::SEG_NONE;
      prev_slash_q <= 1'b0;
    end else if (accept) begin
      first_seen_q <= first_seen_d;
      rejected_q   <= rejected_d;
      out_count_q  <= out_count_d;
      seg_q        <= seg_d;
      prev_slash_q <= prev_slash_d;
    end
  end

  upn_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_valid_i    (load_valid),
    .load_burst_i    (burst),
    .load_ready_o    (load_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import upn_pkg::*;

  // One normalised output transfer: byte, kind and the end-of-path flag.
  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       last;
  } norm_item_t;

  // A row of the directed table. Where typed is set the row closes a path whose only
  // result is the end transfer given in kind; every other row takes its results from the predictor.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    kind_e      kind;
  } dir_row_t;

  localparam int DIR_ROWS     = 25;
  localparam int ITEM_TARGET  = 370;  // input transfers in all, directed rows included
  localparam int STALL_LIMIT  = 500;  // cycles with no transfer on either side
  localparam int DRAIN_CYCLES = 32;   // quiet time after the last expected result
  localparam int PRINT_CAP    = 40;

  localparam logic [7:0] CH_UA  = 8'h41;  // 'A'
  localparam logic [7:0] CH_LX  = 8'h78;  // 'x'
  localparam logic [7:0] CH_LY  = 8'h79;  // 'y'
  localparam logic [7:0] CH_LZ  = 8'h7A;  // 'z'
  localparam logic [7:0] CH_TOP = 8'hFF;
  localparam logic [7:0] CH_MSB = 8'h80;

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // straight after reset: first byte is not a slash, also the last
    '{CH_UA,     1'b1, 1'b1, KIND_REJECT},
    // bare root gives "index.html"
    '{CH_SLASH,  1'b1, 1'b0, KIND_BYTE},
    // a ".." segment in the middle rejects; later bytes are ignored
    '{CH_SLASH,  1'b0, 1'b0, KIND_BYTE},
    '{CH_DOT,    1'b0, 1'b0, KIND_BYTE},
    '{CH_DOT,    1'b0, 1'b0, KIND_BYTE},
    '{CH_SLASH,  1'b0, 1'b0, KIND_BYTE},
    '{CH_LZ,     1'b1, 1'b1, KIND_REJECT},
    // ".x" and "..y" are kept, a final "." is dropped without a suffix
    '{CH_SLASH,  1'b0, 1'b0, KIND_BYTE},
    '{CH_DOT,    1'b0, 1'b0, KIND_BYTE},
    '{CH_LX,     1'b0, 1'b0, KIND_BYTE},
    '{CH_SLASH,  1'b0, 1'b0, KIND_BYTE},
    '{CH_DOT,    1'b0, 1'b0, KIND_BYTE},
    '{CH_DOT,    1'b0, 1'b0, KIND_BYTE},
    '{CH_LY,     1'b0, 1'b0, KIND_BYTE},
    '{CH_SLASH,  1'b0, 1'b0, KIND_BYTE},
    '{CH_DOT,    1'b1, 1'b0, KIND_BYTE},
    // backslash after the first byte
    '{CH_SLASH,  1'b0, 1'b0, KIND_BYTE},
    '{CH_BSLASH, 1'b1, 1'b1, KIND_REJECT},
    // NUL byte, then the top byte value after rejection
    '{CH_SLASH,  1'b0, 1'b0, KIND_BYTE},
    '{CH_NUL,    1'b0, 1'b0, KIND_BYTE},
    '{CH_TOP,    1'b1, 1'b1, KIND_REJECT},
    // high byte values kept as content, trailing slash adds "/index.html"
    '{CH_SLASH,  1'b0, 1'b0, KIND_BYTE},
    '{CH_TOP,    1'b0, 1'b0, KIND_BYTE},
    '{CH_MSB,    1'b0, 1'b0, KIND_BYTE},
    '{CH_SLASH,  1'b1, 1'b0, KIND_BYTE}
  };

  // ---------------------------------------------------------------------------
  // Clock, reset and the block under test
  // ---------------------------------------------------------------------------
  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       s_tvalid      = 1'b0;
  logic [7:0] s_tdata       = 8'h00;
  logic       s_tlast       = 1'b0;
  logic       m_tready      = 1'b0;
  wire        s_tready;
  wire        m_tvalid;
  wire  [7:0] m_tdata;
  wire  [1:0] m_tuser;
  wire        m_tlast;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  url_path_normalizer_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [7:0] path_byte
    .s_axis_tlast_i  (s_tlast),   // final_byte
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [7:0] out_byte
    .m_axis_tuser_o  (m_tuser),   // [1:0] kind
    .m_axis_tlast_o  (m_tlast)    // run_end
  );

  // ---------------------------------------------------------------------------
  // Path normaliser predictor: its own copy of the per-path state
  // ---------------------------------------------------------------------------
  bit          seen_first;
  bit          path_bad;
  bit          after_slash;
  int unsigned emit_cnt;
  seg_e        seg;
  logic [7:0]  dot_hold [2];
  string       suffix_txt = "/index.html";

  norm_item_t  step_out_q [$];  // results of the byte just taken
  norm_item_t  norm_out_q [$];  // normalised output still owed by the block

  function automatic norm_item_t mk_item(input logic [7:0] b, input kind_e k, input logic l);
    norm_item_t it;
    it.data = b;
    it.kind = k;
    it.last = l;
    return it;
  endfunction

  // Emit one byte unless the path is already rejected or would reach capacity.
  function void emit_char(input logic [7:0] b);
    if (path_bad) return;
    if (emit_cnt + 1 >= CAPACITY) begin
      path_bad = 1'b1;
      return;
    end
    step_out_q.push_back(mk_item(b, KIND_BYTE, 1'b0));
    emit_cnt++;
  endfunction

  // Separator only between kept segments, never a leading one.
  function void emit_sep();
    if (emit_cnt > 0) emit_char(CH_SLASH);
  endfunction

  function void close_seg();
    if (seg == SEG_DOTDOT) path_bad = 1'b1;
    seg = SEG_NONE;
  endfunction

  // Hold leading dots until the segment proves itself kept, then flush them.
  function void take_char(input logic [7:0] b);
    case (seg)
      SEG_NONE: begin
        if (b == CH_DOT) begin
          dot_hold[0] = b;
          seg = SEG_DOT;
        end else begin
          emit_sep();
          emit_char(b);
          seg = SEG_KEPT;
        end
      end
      SEG_DOT: begin
        if (b == CH_DOT) begin
          dot_hold[1] = b;
          seg = SEG_DOTDOT;
        end else begin
          emit_sep();
          emit_char(dot_hold[0]);
          emit_char(b);
          seg = SEG_KEPT;
        end
      end
      SEG_DOTDOT: begin
        emit_sep();
        emit_char(dot_hold[0]);
        emit_char(dot_hold[1]);
        emit_char(b);
        seg = SEG_KEPT;
      end
      default: emit_char(b);
    endcase
  endfunction

  function void clear_path();
    seen_first  = 1'b0;
    path_bad    = 1'b0;
    after_slash = 1'b0;
    emit_cnt    = 0;
    seg         = SEG_NONE;
    dot_hold[0] = 8'h00;
    dot_hold[1] = 8'h00;
  endfunction

  // Work out the results caused by one accepted input byte into step_out_q.
  function void normalize_step(input logic [7:0] b, input logic fin);
    step_out_q.delete();
    if (!seen_first) begin
      seen_first  = 1'b1;
      after_slash = 1'b1;
      if (b != CH_SLASH) path_bad = 1'b1;
    end else if (!path_bad) begin
      if (b == CH_SLASH) begin
        close_seg();
        after_slash = 1'b1;
      end else begin
        after_slash = 1'b0;
        if (b == CH_BSLASH || b == CH_NUL) path_bad = 1'b1;
        else take_char(b);
      end
    end
    if (fin) begin
      if (!path_bad) begin
        close_seg();
        if (!path_bad) begin
          if (emit_cnt == 0) begin
            for (int k = 1; k < 11; k++) emit_char(suffix_txt[k]);
          end else if (after_slash) begin
            for (int k = 0; k < 11; k++) emit_char(suffix_txt[k]);
          end
        end
      end
      step_out_q.push_back(mk_item(8'h00, path_bad ? KIND_REJECT : KIND_ACCEPT, 1'b1));
      clear_path();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Path generation
  // ---------------------------------------------------------------------------
  logic [7:0] path_q [$];

  // Segment content: mostly lower-case letters, some dots, some arbitrary bytes.
  function logic [7:0] name_char();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0, 1:    c = CH_DOT;
      2: begin
        do c = 8'($urandom_range(1, 255)); while (c == CH_SLASH || c == CH_BSLASH);
      end
      default: c = 8'($urandom_range(8'h61, 8'h7A));
    endcase
    return c;
  endfunction

  function void build_path();
    int shape;
    int nseg;
    int len;
    int pos;
    path_q.delete();
    shape = $urandom_range(0, 99);
    path_q.push_back(CH_SLASH);
    if (shape < 70) begin
      // well-formed: segments of random content, stray empty segments, dot segments
      nseg = $urandom_range(0, 4);
      for (int s = 0; s < nseg; s++) begin
        if (s > 0) path_q.push_back(CH_SLASH);
        if ($urandom_range(0, 4) == 0) path_q.push_back(CH_SLASH);
        case ($urandom_range(0, 9))
          0: path_q.push_back(CH_DOT);
          1: begin
            if ($urandom_range(0, 2) == 0) begin
              path_q.push_back(CH_DOT);
              path_q.push_back(CH_DOT);
            end else begin
              path_q.push_back(name_char());
            end
          end
          default: begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) path_q.push_back(name_char());
          end
        endcase
      end
      if ($urandom_range(0, 2) == 0) path_q.push_back(CH_SLASH);
    end else if (shape < 85) begin
      // noise after a good leading slash
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++)
        path_q.push_back(($urandom_range(0, 3) == 0) ? CH_SLASH : 8'($urandom_range(0, 255)));
    end else if (shape < 95) begin
      // broken: a backslash or NUL somewhere, the first byte included
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) path_q.push_back(name_char());
      pos = $urandom_range(0, path_q.size() - 1);
      path_q[pos] = ($urandom_range(0, 1) == 1) ? CH_BSLASH : CH_NUL;
    end else begin
      // short runs of slashes and dots
      len = $urandom_range(0, 3);
      for (int i = 0; i < len; i++)
        path_q.push_back(($urandom_range(0, 1) == 1) ? CH_DOT : CH_SLASH);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  int tx_calm;
  int in_xfers;
  int paths_sent;

  // Drive one byte, hold it until the transfer and predict what it causes.
  task automatic send_item(input logic [7:0] b, input logic fin, input bit typed,
                           input kind_e want);
    int gap;
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 49) == 0) tx_calm = $urandom_range(16, 64);
    end
    repeat (gap) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    in_xfers++;
    normalize_step(b, fin);
    if (typed) norm_out_q.push_back(mk_item(8'h00, want, 1'b1));
    else foreach (step_out_q[i]) norm_out_q.push_back(step_out_q[i]);
    if (fin) paths_sent++;
  endtask

  task automatic send_path();
    foreach (path_q[i]) send_item(path_q[i], i == path_q.size() - 1, 1'b0, KIND_BYTE);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure, checking and the mismatch report
  // ---------------------------------------------------------------------------
  int         rx_hold;
  int         rx_calm;
  int         errors;
  int         bytes_seen;
  int         ends_ok;
  int         ends_bad;
  int         idle_cycles;
  norm_item_t head_item;

  task report_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Lower tready for the drawn number of cycles after each result.
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold  = rx_hold - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (norm_out_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result data %02h kind %0d last %0b",
                                  m_tdata, m_tuser, m_tlast));
      end else begin
        head_item = norm_out_q.pop_front();
        if (m_tdata !== head_item.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", m_tdata, head_item.data));
        if (m_tuser !== head_item.kind)
          report_mismatch($sformatf("kind %0d, want %s", m_tuser, head_item.kind.name()));
        if (m_tlast !== head_item.last)
          report_mismatch($sformatf("run_end %0b, want %0b", m_tlast, head_item.last));
        if (head_item.kind == KIND_BYTE) bytes_seen++;
        else if (head_item.kind == KIND_ACCEPT) ends_ok++;
        else ends_bad++;
      end
      if (rx_calm > 0) begin
        rx_calm--;
        rx_hold = 0;
      end else begin
        rx_hold = $urandom_range(0, 5);
        if ($urandom_range(0, 49) == 0) rx_calm = $urandom_range(16, 64);
      end
    end
  end

  // Watchdog: end the run when neither side moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results owed",
                 STALL_LIMIT, norm_out_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed table, random paths, drain
  // ---------------------------------------------------------------------------
  initial begin
    clear_path();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++)
      send_item(DIRECTED[r].data, DIRECTED[r].last, DIRECTED[r].typed, DIRECTED[r].kind);

    // Whole paths only, so the count overshoots by at most one path.
    while (in_xfers < ITEM_TARGET) begin
      build_path();
      send_path();
    end

    @(negedge clk_i);
    s_tvalid <= 1'b0;

    while (norm_out_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d paths in %0d input transfers under random stalls on both sides",
             paths_sent, in_xfers);
    $display("checked %0d path bytes, %0d accepted and %0d rejected ends",
             bytes_seen, ends_ok, ends_bad);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
